/* sv/pdgs_pkg.sv */
// ---------------------------------------------------------------------------
// pdgs_pkg
// shared types and constants of the page dirty generation stamper
// ---------------------------------------------------------------------------
package pdgs_pkg;

   localparam int WINDOW_BYTES_DEF = 32'hA4000;
   localparam int PAGE_SHIFT_DEF   = 12;

   localparam int ADDR_W  = 32;
   localparam int SUM_W   = ADDR_W + 1;
   localparam int COUNT_W = 32;
   localparam int PAGE_OUT_W = 8;

   localparam logic [COUNT_W-1:0] GEN_RESET = 32'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_CLIP,
      S_PAGE,
      S_STAMP,
      S_DONE,
      S_CLEAR
   } state_type;

endpackage

/* sv/page_dirty_generation_stamper_unit.sv */
// ---------------------------------------------------------------------------
// page_dirty_generation_stamper_unit
// stamps the pages of a memory window touched by a write notice with a
// fresh generation number
// ---------------------------------------------------------------------------
// Usage:
//   A request on req_* carries one write notice (absolute address, byte
//   length). The csr_* port sets the window base; write it only while idle.
//   Each request produces exactly one response on rsp_*: a touched flag in
//   rsp_tuser, the generation, the first and last page and the call count.
//   For a request that hits the window, a small sequencer forms the address
//   sums over three steps and then writes the page table one entry per
//   cycle, one entry for each page stamped (up to 164 at the default
//   window). An ignored request stamps no page and leaves the counters
//   alone. One request is worked on at a time; req_tready is high only
//   while the sequencer is idle, so a new request is taken only after the
//   previous one has been written to the output register.
//   The response sits in an output register, so the next request can be
//   taken while a stalled response waits; the sequencer holds a finished
//   request until the output register is free.
//   Reset clears both counters (generation back to one, calls to zero), the
//   window base and all handshake state, then zeroes the page table one
//   entry per cycle with req_tready low.
// ---------------------------------------------------------------------------
module page_dirty_generation_stamper_unit #(
   parameter int WINDOW_BYTES = pdgs_pkg::WINDOW_BYTES_DEF,
   parameter int PAGE_SHIFT   = pdgs_pkg::PAGE_SHIFT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,  // write_address, write_length
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [79:0]                      rsp_tdata,  // stamp_generation, first_page,
                                                        // last_page, stamp_calls
   output logic [0:0]                       rsp_tuser,  // touched
   input  logic                             csr_wr_en,
   input  logic [pdgs_pkg::ADDR_W-1:0]      csr_wr_data
);
   import pdgs_pkg::*;

   localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
   localparam int NUM_PAGES  = (WINDOW_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int PAGE_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam logic [SUM_W-1:0] WIN_LIMIT = SUM_W'(WINDOW_BYTES);
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       base_ff;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       len_ff, len_in;
   logic [SUM_W-1:0]        end_ff, end_in;
   logic [SUM_W-1:0]        limit_ff, limit_in;
   logic [SUM_W-1:0]        lo_ff, lo_in;
   logic [SUM_W-1:0]        hi_ff, hi_in;
   logic [PAGE_W-1:0]       first_ff, first_in;
   logic [PAGE_W-1:0]       last_ff, last_in;
   logic [PAGE_W-1:0]       pg_ff, pg_in;
   logic                    touched_ff, touched_in;
   logic [COUNT_W-1:0]      gen_ff, gen_in;
   logic [COUNT_W-1:0]      calls_ff, calls_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_touched_ff, rsp_touched_in;
   logic [COUNT_W-1:0]      rsp_gen_ff, rsp_gen_in;
   logic [PAGE_OUT_W-1:0]   rsp_first_ff, rsp_first_in;
   logic [PAGE_OUT_W-1:0]   rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]      rsp_calls_ff, rsp_calls_in;
   logic                    stamp_we;
   logic [COUNT_W-1:0]      stamp_data;
   logic [SUM_W-1:0]        hi_clip;
   logic [SUM_W-1:0]        hi_dec;

   logic [COUNT_W-1:0]      page_mem [NUM_PAGES];

   assign hi_clip = (hi_ff > WIN_LIMIT) ? WIN_LIMIT : hi_ff;
   assign hi_dec  = hi_clip - SUM_W'(1);

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      len_in         = len_ff;
      end_in         = end_ff;
      limit_in       = limit_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      pg_in          = pg_ff;
      touched_in     = touched_ff;
      gen_in         = gen_ff;
      calls_in       = calls_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_touched_in = rsp_touched_ff;
      rsp_gen_in     = rsp_gen_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_calls_in   = rsp_calls_ff;
      req_tready     = 1'b0;
      stamp_we       = 1'b0;
      stamp_data     = gen_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               addr_in  = req_tdata[31:0];
               len_in   = req_tdata[63:32];
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            end_in   = {1'b0, addr_ff} + {1'b0, len_ff};
            limit_in = {1'b0, base_ff} + WIN_LIMIT;
            state_in = S_CLIP;
         end
         S_CLIP: begin
            lo_in = (addr_ff < base_ff) ? '0 : ({1'b0, addr_ff} - {1'b0, base_ff});
            hi_in = end_ff - {1'b0, base_ff};
            if ((len_ff == '0) || ({1'b0, addr_ff} >= limit_ff)
                || (end_ff <= {1'b0, base_ff})) begin
               touched_in = 1'b0;
               first_in   = '0;
               last_in    = '0;
               state_in   = S_DONE;
            end else begin
               state_in = S_PAGE;
            end
         end
         S_PAGE: begin
            touched_in = 1'b1;
            first_in   = PAGE_W'(lo_ff >> PAGE_SHIFT);
            last_in    = PAGE_W'(hi_dec >> PAGE_SHIFT);
            pg_in      = PAGE_W'(lo_ff >> PAGE_SHIFT);
            gen_in     = gen_ff + COUNT_W'(1);
            calls_in   = calls_ff + COUNT_W'(1);
            state_in   = S_STAMP;
         end
         S_STAMP: begin
            stamp_we = 1'b1;
            pg_in    = pg_ff + 1'b1;
            if (pg_ff == last_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_touched_in = touched_ff;
               rsp_gen_in     = gen_ff;
               rsp_first_in   = PAGE_OUT_W'(first_ff);
               rsp_last_in    = PAGE_OUT_W'(last_ff);
               rsp_calls_in   = calls_ff;
               state_in       = S_IDLE;
            end
         end
         S_CLEAR: begin
            // zero the page table after reset
            stamp_we   = 1'b1;
            stamp_data = '0;
            pg_in      = pg_ff + 1'b1;
            if (pg_ff == LAST_PAGE) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         base_ff      <= '0;
         gen_ff       <= GEN_RESET;
         calls_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pg_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         calls_ff     <= calls_in;
         rsp_valid_ff <= rsp_valid_in;
         pg_ff        <= pg_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      len_ff         <= len_in;
      end_ff         <= end_in;
      limit_ff       <= limit_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      touched_ff     <= touched_in;
      rsp_touched_ff <= rsp_touched_in;
      rsp_gen_ff     <= rsp_gen_in;
      rsp_first_ff   <= rsp_first_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_calls_ff   <= rsp_calls_in;
   end

   // page table, one stamp per cycle
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         page_mem[pg_ff] <= stamp_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_touched_ff;
   assign rsp_tdata  = {rsp_calls_ff, rsp_last_ff, rsp_first_ff, rsp_gen_ff};

   // stamping sweep ends at the last page
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STAMP && pg_ff == last_ff) |=> (state_ff == S_DONE))
      else $error("stamp sweep did not end at last page");

   // sweep never runs past the last page
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STAMP) |-> (pg_ff <= last_ff && first_ff <= last_ff))
      else $error("stamp page out of range");

   // generation and call count advance together
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAGE) |=> (gen_ff == $past(gen_ff) + COUNT_W'(1)
                               && calls_ff == $past(calls_ff) + COUNT_W'(1)))
      else $error("counters did not advance together");

   // counters only move in the page step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PAGE) |=> $stable(gen_ff) && $stable(calls_ff))
      else $error("counter changed outside page step");

endmodule

/* dv/page_stamp_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_stamp_checker
// watches the csr, request and response channels of the stamper, predicts
// each response from its own copy of the window base and counters, and
// compares the responses field by field in order
// ---------------------------------------------------------------------------
module page_stamp_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [63:0]                  req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [79:0]                  rsp_tdata,
   input  logic [0:0]                   rsp_tuser,
   input  logic                         csr_wr_en,
   input  logic [pdgs_pkg::ADDR_W-1:0]  csr_wr_data,
   output int                           error_count,
   output int                           outstanding
);
   import pdgs_pkg::*;

   localparam logic [SUM_W-1:0] WINDOW_SPAN = SUM_W'(WINDOW_BYTES_DEF);

   typedef struct packed {
      logic                      touched;
      logic [COUNT_W-1:0]        generation;
      logic [PAGE_OUT_W-1:0]     first_page;
      logic [PAGE_OUT_W-1:0]     last_page;
      logic [COUNT_W-1:0]        calls;
   } stamp_result_type;

   logic [ADDR_W-1:0]    window_base = '0;
   logic [COUNT_W-1:0]   current_gen = GEN_RESET;
   logic [COUNT_W-1:0]   call_total  = '0;
   stamp_result_type     expected_stamps[$];
   int                   errors = 0;
   int                   waiting = 0;

   assign error_count = errors;
   assign outstanding = waiting;

   function automatic stamp_result_type predict_stamp(input logic [31:0] address,
                                                      input logic [31:0] length);
      stamp_result_type    r;
      logic [SUM_W-1:0]    base_x;
      logic [SUM_W-1:0]    start_x;
      logic [SUM_W-1:0]    end_x;
      logic [SUM_W-1:0]    lo;
      logic [SUM_W-1:0]    hi;
      base_x  = {1'b0, window_base};
      start_x = {1'b0, address};
      end_x   = start_x + {1'b0, length};
      r = '0;
      // ignored notice reports the unchanged counters
      if (length == 0 || start_x >= base_x + WINDOW_SPAN || end_x <= base_x) begin
         r.generation = current_gen;
         r.calls      = call_total;
         return r;
      end
      lo = (start_x < base_x) ? '0 : start_x - base_x;
      hi = end_x - base_x;
      if (hi > WINDOW_SPAN) begin
         hi = WINDOW_SPAN;
      end
      current_gen = current_gen + 1'b1;
      call_total  = call_total + 1'b1;
      r.touched    = 1'b1;
      r.generation = current_gen;
      r.first_page = PAGE_OUT_W'(lo >> PAGE_SHIFT_DEF);
      r.last_page  = PAGE_OUT_W'((hi - 1'b1) >> PAGE_SHIFT_DEF);
      r.calls      = call_total;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: response mismatch on %s: got %h, expected %h", $time, what, got,
               want);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      stamp_result_type got;
      stamp_result_type want;
      if (reset) begin
         window_base = '0;
         current_gen = GEN_RESET;
         call_total  = '0;
         expected_stamps.delete();
      end else begin
         if (csr_wr_en) begin
            window_base = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            expected_stamps.push_back(predict_stamp(req_tdata[31:0], req_tdata[63:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.touched    = rsp_tuser[0];
            got.generation = rsp_tdata[31:0];
            got.first_page = rsp_tdata[39:32];
            got.last_page  = rsp_tdata[47:40];
            got.calls      = rsp_tdata[79:48];
            if (expected_stamps.size() == 0) begin
               report_mismatch("unexpected response", got.generation, '0);
            end else begin
               want = expected_stamps.pop_front();
               if (got.touched != want.touched)
                  report_mismatch("touched", 32'(got.touched), 32'(want.touched));
               if (got.generation != want.generation)
                  report_mismatch("stamp_generation", got.generation, want.generation);
               if (got.first_page != want.first_page)
                  report_mismatch("first_page", 32'(got.first_page),
                                  32'(want.first_page));
               if (got.last_page != want.last_page)
                  report_mismatch("last_page", 32'(got.last_page), 32'(want.last_page));
               if (got.calls != want.calls)
                  report_mismatch("stamp_calls", got.calls, want.calls);
            end
         end
      end
      waiting = expected_stamps.size();
   end

endmodule

/* dv/page_dirty_generation_stamper_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_dirty_generation_stamper_unit_tb
// drives write notices through the stamper under several window bases,
// first a directed set of edge cases, then random notices clustered around
// the window, with random gaps and stalls on both channels
// ---------------------------------------------------------------------------
module page_dirty_generation_stamper_unit_tb;
   import pdgs_pkg::*;

   localparam logic [31:0] WIN = 32'(WINDOW_BYTES_DEF);
   localparam int PHASE_ITEMS = 125;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   int          error_count;
   int          outstanding;

   logic        quiet = 1'b0;
   logic        hold_rsp = 1'b0;
   logic [31:0] cur_base = '0;

   always #1 clock = ~clock;

   page_dirty_generation_stamper_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   page_stamp_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic offer_notice(input logic [31:0] address, input logic [31:0] length);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {length, address};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and let every outstanding response drain
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_window_base(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_base = value;
   endtask

   task automatic random_notice(output logic [31:0] address, output logic [31:0] length);
      int          kind;
      int          len_kind;
      logic [31:0] off;
      kind     = $urandom_range(0, 9);
      len_kind = $urandom_range(0, 9);
      off      = $urandom_range(0, WIN + 32'h2000);
      address  = cur_base + off - 32'h1000;
      if (len_kind < 6) begin
         length = $urandom_range(1, 32'h3000);
      end else if (len_kind < 8) begin
         length = $urandom_range(1, WIN + 32'h2000);
      end else if (len_kind == 8) begin
         length = $urandom();
      end else begin
         length = $urandom_range(1, 16);
      end
      case (kind)
         0: begin
            address = $urandom();
            length  = $urandom();
         end
         1: length = '0;
         2: begin
            if ($urandom_range(0, 1) == 0) begin
               // ends at or below the window base
               off     = $urandom_range(1, 32'h10000);
               address = cur_base - off;
               length  = $urandom_range(1, off);
            end else begin
               address = cur_base + WIN + $urandom_range(0, 32'h10000);
            end
         end
         default: ;
      endcase
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin : response_side
      int gap;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            gap = 600;
         end else begin
            gap = draw_gap();
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : timeout
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] bases[6];
      logic [31:0] address;
      logic [31:0] length;
      bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFF5_C000, 32'h0000_0800,
                32'h8000_0000, 32'h0};
      bases[5] = $urandom();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, window base at its reset value
      offer_notice(32'h0, 32'h0);
      offer_notice(32'h0, 32'h1);
      offer_notice(32'h0, WIN);
      offer_notice(32'h0, 32'hFFFF_FFFF);
      offer_notice(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_notice(WIN, 32'h1);
      offer_notice(WIN - 1, 32'h1);
      offer_notice(32'h0000_0FFF, 32'h2);
      offer_notice(32'h0000_1000, 32'h1000);
      offer_notice(32'h0000_5000, 32'h0);
      offer_notice(32'h8000_0000, 32'h1);
      offer_notice(WIN - 1, 32'hFFFF_FFFF);
      drain_responses();

      // directed, window moved up
      write_window_base(32'h0001_0000);
      offer_notice(32'h0, 32'h0001_0000);
      offer_notice(32'h0, 32'h0001_0001);
      offer_notice(32'h0001_0000 + WIN, 32'h5);
      offer_notice(32'h0000_FFFF, WIN + 32'h2);
      offer_notice(32'hFFFF_FFFF, 32'h1);
      offer_notice(32'h0001_0000 + WIN - 1, 32'h8000_0000);
      drain_responses();

      for (int p = 0; p < 6; p++) begin
         write_window_base(bases[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) begin
               quiet = ($urandom_range(0, 3) == 0);
            end
            // receiver holds off while requests keep coming
            if (i == 10) begin
               hold_rsp = 1'b1;
            end
            random_notice(address, length);
            offer_notice(address, length);
         end
         quiet = 1'b0;
         drain_responses();
      end

      repeat (180) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
